>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: assertion failed");
// Clocked next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: assertion failed");
`endif

>>> hw/rtl/pklerp_pkg.sv
// Types and constants of the keyframe lerp sampler
package pklerp_pkg;
  localparam int unsigned FrameW = 24;
  localparam int unsigned ValW   = 32;
  localparam int unsigned StW    = 3;
  localparam int unsigned ProdW  = 57;
  localparam int unsigned QuotW  = 32;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_SAMPLED  = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_ACCEPTED = 3'd2,
    ST_REJECTED = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDFIRST,
    S_RDLAST,
    S_CLAMP,
    S_PROBE,
    S_PROBEWAIT,
    S_RD0,
    S_RD1,
    S_RD1WAIT,
    S_DIV,
    S_OUT
  } state_e;
endpackage

>>> hw/rtl/pklerp_if.sv
// Valid/ready channel interfaces of the lerp sampler
interface pklerp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [23:0] frame;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  logic signed [31:0] value_z;
  modport source (output valid, func, frame, value_x, value_y, value_z, input ready);
  modport sink   (input valid, func, frame, value_x, value_y, value_z, output ready);
endinterface

interface pklerp_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [2:0]  status;
  modport source (output valid, pos_x, pos_y, pos_z, status, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, status, output ready);
endinterface

>>> hw/rtl/pklerp_div.sv
// Serial signed divider: 57-bit dividend by 24-bit positive divisor, one bit a cycle
module pklerp_div import pklerp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ProdW-1:0] num_i,
  input  logic [FrameW-1:0]       den_i,
  output logic                    busy_o,
  output logic signed [ValW-1:0]  quot_o
);
  localparam int unsigned CntW = $clog2(ProdW + 1);

  logic [ProdW-1:0]   mag_q, mag_d;
  logic [FrameW:0]    rem_q, rem_d;
  logic [FrameW-1:0]  den_q;
  logic [QuotW-1:0]   quo_q, quo_d;
  logic               neg_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [FrameW:0]    trial;
  logic [FrameW+1:0]  diff;

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[FrameW-1:0], mag_q[ProdW-1]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    if (start_i) begin
      mag_d  = num_i[ProdW-1] ? ProdW'(-num_i) : num_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntW'(ProdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[ProdW-2:0], 1'b0};
      if (!diff[FrameW+1]) begin
        rem_d = diff[FrameW:0];
        quo_d = {quo_q[QuotW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[QuotW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[ProdW-1];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? -ValW'(signed'({1'b0, quo_q})) : ValW'(signed'({1'b0, quo_q}));
endmodule

>>> hw/rtl/position_key_lerp_sampler_top.sv
// Keyframe track: append, clear and sample with linear interpolation
// Clear, append, unknown items and samples of an empty track go from idle straight to the output state.
// Exact-hit or clamped samples skip the divider; interpolated samples run the serial divider once per axis.
// The binary search makes at most ceil(log2(keys)) probes.
// One transaction in flight at a time; the next is taken only after the result has been accepted.
// Reset empties the track; key memories are not cleared.
module position_key_lerp_sampler_top import pklerp_pkg::*; #(
  parameter int unsigned MAX_KEYS = 256
) (
  input logic          clk_i,
  input logic          rst_ni,
  pklerp_in_if.sink    in_i,
  pklerp_out_if.source out_o
);
  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned NW = $clog2(MAX_KEYS + 1);

  logic [FrameW-1:0] mem_f [MAX_KEYS];
  logic [3*ValW-1:0] mem_p [MAX_KEYS];

  state_e state_q, state_d;
  logic [NW-1:0] n_q, n_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, mid, raddr;
  logic [FrameW-1:0] f_q, f_d, rf_q, lastf_q, lastf_d;
  logic [3*ValW-1:0] rp_q, p0_q, p0_d;
  logic [1:0] comp_q, comp_d;
  logic [ValW-1:0] rx_q, ry_q, rz_q, rx_d, ry_d, rz_d;
  logic [StW-1:0] st_q, st_d;
  logic ov_q, ov_d;
  logic [FrameW-1:0] den_q, den_d, num_q, num_d;
  logic we;
  logic div_start;
  logic div_busy;
  logic signed [ValW:0] dp;
  logic signed [ProdW-1:0] prod;
  logic signed [ValW-1:0] quot, pc0, ps0, ps1;

  assign in_i.ready  = (state_q == S_IDLE) && !ov_q;
  assign out_o.valid = ov_q;
  assign out_o.pos_x = rx_q;
  assign out_o.pos_y = ry_q;
  assign out_o.pos_z = rz_q;
  assign out_o.status = st_q;

  wire acc = in_i.valid && in_i.ready;
  assign mid = AW'(({1'b0, lo_q} + {1'b0, hi_q} + 1'b1) >> 1);

  // pc0 is the component being written back; ps0/ps1 feed the next division
  always_comb begin
    case (comp_q)
      2'd0:    pc0 = p0_q[3*ValW-1 -: ValW];
      2'd1:    pc0 = p0_q[2*ValW-1 -: ValW];
      default: pc0 = p0_q[ValW-1:0];
    endcase
    case (comp_d)
      2'd0: begin
        ps0 = p0_q[3*ValW-1 -: ValW];
        ps1 = rp_q[3*ValW-1 -: ValW];
      end
      2'd1: begin
        ps0 = p0_q[2*ValW-1 -: ValW];
        ps1 = rp_q[2*ValW-1 -: ValW];
      end
      default: begin
        ps0 = p0_q[ValW-1:0];
        ps1 = rp_q[ValW-1:0];
      end
    endcase
    dp  = (ValW+1)'(ps1) - (ValW+1)'(ps0);
    prod = ProdW'(dp) * signed'(ProdW'({1'b0, num_q}));
  end

  pklerp_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(prod), .den_i(den_d),
    .busy_o(div_busy), .quot_o(quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (acc) begin
        case (in_i.func)
          FUNC_SAMPLE: state_d = (n_q == '0) ? S_OUT : S_RDFIRST;
          FUNC_APPEND: state_d = S_OUT;
          default:     state_d = S_OUT;
        endcase
      end
      S_RDFIRST: state_d = S_RDLAST;
      S_RDLAST:  state_d = S_CLAMP;
      S_CLAMP:   state_d = (lo_d < hi_d) ? S_PROBE : S_RD0;
      S_PROBE:   state_d = S_PROBEWAIT;
      S_PROBEWAIT: state_d = (lo_d < hi_d) ? S_PROBE : S_RD0;
      S_RD0:     state_d = S_RD1;
      S_RD1:     state_d = S_RD1WAIT;
      S_RD1WAIT: state_d = S_DIV;
      S_DIV:     if (div_start == 1'b0 && !div_busy && comp_q == 2'd3) state_d = S_OUT;
      S_OUT:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    n_d = n_q; lo_d = lo_q; hi_d = hi_q; f_d = f_q; lastf_d = lastf_q;
    p0_d = p0_q; comp_d = comp_q; rx_d = rx_q; ry_d = ry_q; rz_d = rz_q;
    st_d = st_q; ov_d = ov_q; den_d = den_q; num_d = num_q;
    we = 1'b0; raddr = lo_q; div_start = 1'b0;
    if (out_o.ready) ov_d = 1'b0;
    case (state_q)
      S_IDLE: if (acc) begin
        rx_d = '0; ry_d = '0; rz_d = '0; f_d = in_i.frame;
        case (in_i.func)
          FUNC_SAMPLE: begin
            st_d = (n_q == '0) ? ST_EMPTY : ST_SAMPLED;
            raddr = '0;
          end
          FUNC_APPEND: begin
            if (n_q >= NW'(MAX_KEYS) || (n_q != '0 && in_i.frame <= lastf_q)) begin
              st_d = ST_REJECTED;
            end else begin
              st_d = ST_ACCEPTED; we = 1'b1; lastf_d = in_i.frame; n_d = n_q + 1'b1;
            end
          end
          FUNC_CLEAR: begin st_d = ST_CLEARED; n_d = '0; end
          default: st_d = ST_REJECTED;
        endcase
      end
      S_RDFIRST: begin
        raddr = AW'(n_q - 1'b1);
        if (f_q < rf_q) f_d = rf_q;
      end
      S_RDLAST: begin
        if (f_q > rf_q) f_d = rf_q;
      end
      S_CLAMP: begin
        lo_d = '0; hi_d = AW'(n_q - 1'b1);
        raddr = mid;
      end
      S_PROBE: raddr = mid;
      S_PROBEWAIT: begin
        if (rf_q <= f_q) lo_d = mid; else hi_d = mid - 1'b1;
        raddr = mid;
      end
      S_RD0: raddr = lo_q;
      S_RD1: begin
        raddr = (32'(lo_q) + 1 < 32'(n_q)) ? AW'(lo_q + 1'b1) : lo_q;
        p0_d = rp_q; num_d = f_q - rf_q;
        comp_d = 2'd0;
      end
      S_RD1WAIT: begin
        den_d = rf_q - f_q + num_q;
        if (num_q == '0 || 32'(lo_q) + 1 >= 32'(n_q)) begin
          rx_d = p0_q[3*ValW-1 -: ValW]; ry_d = p0_q[2*ValW-1 -: ValW];
          rz_d = p0_q[ValW-1:0]; comp_d = 2'd3;
        end else begin
          div_start = 1'b1;
        end
      end
      S_DIV: if (!div_busy && comp_q != 2'd3) begin
        case (comp_q)
          2'd0: rx_d = ValW'(pc0 + quot);
          2'd1: ry_d = ValW'(pc0 + quot);
          default: rz_d = ValW'(pc0 + quot);
        endcase
        comp_d = comp_q + 1'b1;
        if (comp_q != 2'd2) div_start = 1'b1;
      end
      S_OUT: ov_d = 1'b1;
      default: ;
    endcase
    if (state_q == S_DIV && div_busy) raddr = AW'(lo_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; n_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; n_q <= n_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; f_q <= f_d; lastf_q <= lastf_d; p0_q <= p0_d;
    comp_q <= comp_d; rx_q <= rx_d; ry_q <= ry_d; rz_q <= rz_d; st_q <= st_d;
    den_q <= den_d; num_q <= num_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_f[n_q[AW-1:0]] <= in_i.frame;
      mem_p[n_q[AW-1:0]] <= {in_i.value_x, in_i.value_y, in_i.value_z};
    end
    rf_q <= mem_f[raddr];
    rp_q <= mem_p[raddr];
  end
endmodule

>>> hw/rtl/pklerp_chk.sv
// Port-level checker for the lerp sampler, bound to the top level
`include "assert_macros.svh"
module pklerp_chk import pklerp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] pos_x
);
  `ASSERT_IMPL(a_no_accept_pending, clk_i, rst_ni, out_valid, !in_ready)
  `ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(status))
  `ASSERT_IMPL(a_status_range, clk_i, rst_ni, out_valid,
               status == ST_SAMPLED || status == ST_EMPTY || status == ST_ACCEPTED ||
               status == ST_REJECTED || status == ST_CLEARED)
  `ASSERT_IMPL(a_zero_unsampled, clk_i, rst_ni, out_valid && status != ST_SAMPLED, pos_x == '0)
endmodule

bind position_key_lerp_sampler_top pklerp_chk u_chk (
  .clk_i, .rst_ni, .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .status(out_o.status), .pos_x(out_o.pos_x)
);

>>> test/pklerp_checker.sv
// Checker for the keyframe lerp sampler: predicts each result and compares it
module pklerp_checker import pklerp_pkg::*; #(
  parameter int unsigned MAX_KEYS = 256
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pklerp_in_if  in_m,
  pklerp_out_if out_m,
  output int    errors_o,
  output int    pending_o,
  output int    interpolated_o
);
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    status_e            st;
  } position_t;

  logic [23:0]        key_frame_mem [MAX_KEYS];
  logic signed [31:0] key_x_mem [MAX_KEYS];
  logic signed [31:0] key_y_mem [MAX_KEYS];
  logic signed [31:0] key_z_mem [MAX_KEYS];
  int                 key_count;
  position_t          expected_positions [$];

  function automatic logic signed [31:0] lerp_axis(logic signed [31:0] p0,
      logic signed [31:0] p1, longint num, longint den);
    longint d;
    longint q;
    d = longint'(p1) - longint'(p0);
    q = (d * num) / den;
    return 32'(longint'(p0) + q);
  endfunction

  // updates the track copy and returns the result the transaction must give
  function automatic position_t predict_position(logic [1:0] fn, logic [23:0] f,
      logic signed [31:0] vx, logic signed [31:0] vy, logic signed [31:0] vz);
    position_t r;
    int        i;
    longint    num;
    longint    den;
    r = '{x: 0, y: 0, z: 0, st: ST_REJECTED};
    case (func_e'(fn))
      FUNC_SAMPLE: begin
        if (key_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          if (f < key_frame_mem[0]) f = key_frame_mem[0];
          if (f > key_frame_mem[key_count-1]) f = key_frame_mem[key_count-1];
          i = 0;
          for (int j = 0; j < key_count; j++)
            if (key_frame_mem[j] <= f) i = j;
          r.st = ST_SAMPLED;
          if (key_frame_mem[i] == f || i + 1 >= key_count) begin
            r.x = key_x_mem[i];
            r.y = key_y_mem[i];
            r.z = key_z_mem[i];
          end else begin
            num = longint'(f) - longint'(key_frame_mem[i]);
            den = longint'(key_frame_mem[i+1]) - longint'(key_frame_mem[i]);
            r.x = lerp_axis(key_x_mem[i], key_x_mem[i+1], num, den);
            r.y = lerp_axis(key_y_mem[i], key_y_mem[i+1], num, den);
            r.z = lerp_axis(key_z_mem[i], key_z_mem[i+1], num, den);
            interpolated_o++;
          end
        end
      end
      FUNC_APPEND: begin
        if (key_count < MAX_KEYS &&
            (key_count == 0 || f > key_frame_mem[key_count-1])) begin
          key_frame_mem[key_count] = f;
          key_x_mem[key_count] = vx;
          key_y_mem[key_count] = vy;
          key_z_mem[key_count] = vz;
          key_count++;
          r.st = ST_ACCEPTED;
        end
      end
      FUNC_CLEAR: begin
        key_count = 0;
        r.st = ST_CLEARED;
      end
      default: r.st = ST_REJECTED;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    position_t e;
    if (!rst_ni) begin
      key_count = 0;
      expected_positions.delete();
      errors_o = 0;
      interpolated_o = 0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h status=%0d", $time,
                   out_m.pos_x, out_m.pos_y, out_m.pos_z, out_m.status);
          errors_o++;
        end else begin
          e = expected_positions.pop_front();
          if (out_m.pos_x !== e.x) begin
            $display("%0t: pos_x expected %h actual %h", $time, e.x, out_m.pos_x);
            errors_o++;
          end
          if (out_m.pos_y !== e.y) begin
            $display("%0t: pos_y expected %h actual %h", $time, e.y, out_m.pos_y);
            errors_o++;
          end
          if (out_m.pos_z !== e.z) begin
            $display("%0t: pos_z expected %h actual %h", $time, e.z, out_m.pos_z);
            errors_o++;
          end
          if (out_m.status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, out_m.status);
            errors_o++;
          end
        end
      end
      if (in_m.valid && in_m.ready)
        expected_positions.push_back(predict_position(in_m.func, in_m.frame,
            in_m.value_x, in_m.value_y, in_m.value_z));
    end
  end

  assign pending_o = expected_positions.size();
endmodule

>>> test/tb_position_key_lerp_sampler_top.sv
// Testbench top of the keyframe lerp sampler: stimulus, handshakes and verdict
module tb_position_key_lerp_sampler_top;
  import pklerp_pkg::*;

  localparam int unsigned MaxKeys = 256;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   interpolated;
  int   sent;
  int   fill_runs;
  int   stall_left;
  bit   calm;
  logic [23:0] last_frame;
  logic [23:0] first_frame;
  bit   have_keys;

  pklerp_in_if  in_ch ();
  pklerp_out_if out_ch ();

  position_key_lerp_sampler_top #(.MAX_KEYS(MaxKeys)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  pklerp_checker #(.MAX_KEYS(MaxKeys)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_m          (in_ch),
    .out_m         (out_ch),
    .errors_o      (errors),
    .pending_o     (pending),
    .interpolated_o(interpolated)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) calm = !calm;
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  task automatic send(func_e fn, logic [23:0] f, logic [31:0] vx = $urandom,
      logic [31:0] vy = $urandom, logic [31:0] vz = $urandom);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.func = fn;
    in_ch.frame = f;
    in_ch.value_x = vx;
    in_ch.value_y = vy;
    in_ch.value_z = vz;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic append_run(int nk);
    logic [23:0] f;
    int step;
    for (int k = 0; k < nk; k++) begin
      step = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200000)
                                          : $urandom_range(1, 600);
      if (!have_keys) f = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(0, 5000));
      else if (32'(last_frame) + step > 32'hFFFFFF) f = 24'hFFFFFF;
      else f = last_frame + 24'(step);
      if ($urandom_range(0, 19) == 0 && have_keys)
        f = 24'($urandom_range(0, last_frame));
      send(FUNC_APPEND, f);
      if (!have_keys) begin
        first_frame = f;
        last_frame = f;
        have_keys = 1'b1;
      end else if (f > last_frame) begin
        last_frame = f;
      end
    end
  endtask

  task automatic sample_run(int ns);
    logic [23:0] lo;
    logic [23:0] hi;
    for (int k = 0; k < ns; k++) begin
      lo = (first_frame > 50) ? first_frame - 24'd50 : 24'd0;
      hi = (last_frame < 24'hFFFFCD) ? last_frame + 24'd50 : 24'hFFFFFF;
      if (!have_keys || $urandom_range(0, 9) == 0)
        send(FUNC_SAMPLE, 24'($urandom));
      else
        send(FUNC_SAMPLE, 24'($urandom_range(lo, hi)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_SAMPLE;
    in_ch.frame = '0;
    in_ch.value_x = '0;
    in_ch.value_y = '0;
    in_ch.value_z = '0;
    out_ch.ready = 1'b0;
    stall_left = 0;
    calm = 1'b0;
    sent = 0;
    fill_runs = 0;
    have_keys = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty track, unknown function, extremes, rejected appends, clamping, exact hits, interpolation
    send(FUNC_SAMPLE, 24'd0);
    send(FUNC_NONE, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(FUNC_APPEND, 24'd0, 32'h80000000, 32'h7FFFFFFF, 32'h00000000);
    send(FUNC_SAMPLE, 24'hFFFFFF);
    send(FUNC_APPEND, 24'd0, 32'h1, 32'h1, 32'h1);
    send(FUNC_APPEND, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    send(FUNC_APPEND, 24'hFFFFFF, 32'h0, 32'h0, 32'h0);
    send(FUNC_SAMPLE, 24'd1);
    send(FUNC_SAMPLE, 24'h7FFFFF);
    send(FUNC_SAMPLE, 24'hFFFFFE);
    send(FUNC_SAMPLE, 24'hFFFFFF);
    send(FUNC_SAMPLE, 24'd0);
    send(FUNC_CLEAR, 24'd0);
    send(FUNC_SAMPLE, 24'd100);
    send(FUNC_APPEND, 24'd100, 32'h00010000, 32'hFFFF0000, 32'h0);
    send(FUNC_APPEND, 24'd103, 32'h00020000, 32'hFFFE0000, 32'h5);
    send(FUNC_APPEND, 24'd200, 32'h00030000, 32'h00000000, 32'hFFFFFFFB);
    send(FUNC_SAMPLE, 24'd99);
    send(FUNC_SAMPLE, 24'd101);
    send(FUNC_SAMPLE, 24'd103);
    send(FUNC_SAMPLE, 24'd150);
    send(FUNC_SAMPLE, 24'd201);
    drain();

    // random sequences: unknown functions, drains, clears with runs of appends and samples, lone appends and samples
    send(FUNC_CLEAR, 24'($urandom));
    have_keys = 1'b0;
    while (sent < 1000) begin
      case ($urandom_range(0, 19))
        0: begin
          send(FUNC_NONE, 24'($urandom));
        end
        1: begin
          drain();
        end
        2: begin
          send(FUNC_CLEAR, 24'($urandom));
          have_keys = 1'b0;
          if (fill_runs < 2) begin
            fill_runs++;
            append_run(MaxKeys + 4);
            sample_run(12);
          end
        end
        3, 4, 5: begin
          send(FUNC_CLEAR, 24'($urandom));
          have_keys = 1'b0;
          if ($urandom_range(0, 3) == 0) sample_run(1);
          append_run($urandom_range(1, 12));
          sample_run($urandom_range(1, 15));
        end
        6, 7: begin
          append_run($urandom_range(1, 4));
        end
        default: begin
          sample_run($urandom_range(1, 6));
        end
      endcase
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d transactions: empty, full and out-of-order tracks,", sent);
    $display("clamped and exact samples, %0d interpolated samples, unknown functions.",
             interpolated);
    if (errors == 0 && pending == 0) begin
      $display("tb_position_key_lerp_sampler_top: PASS");
    end else begin
      $display("tb_position_key_lerp_sampler_top: FAIL");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("tb_position_key_lerp_sampler_top: FAIL");
    $finish;
  end
endmodule
